// ----- rtl/gfpb_pkg.sv -----
package gfpb_pkg;

   localparam int CFG_BITS    = 16;
   localparam int POS_BITS    = CFG_BITS + 1;
   localparam int KEY_BITS    = 9;
   localparam int INDEX_BITS  = 8;
   localparam int RGB_BITS    = 24;
   localparam int ADDR_BITS   = 32;
   localparam int PROD_BITS   = POS_BITS + CFG_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   localparam logic [KEY_BITS-1:0] KEY_NONE = 9'd256;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_CANVAS_WIDTH  = 3'd0,
      REG_CANVAS_HEIGHT = 3'd1,
      REG_FRAME_LEFT    = 3'd2,
      REG_FRAME_TOP     = 3'd3,
      REG_FRAME_WIDTH   = 3'd4,
      REG_FRAME_HEIGHT  = 3'd5,
      REG_INTERLACED    = 3'd6,
      REG_TRANSP_KEY    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] canvas_width;
      logic [CFG_BITS-1:0] canvas_height;
      logic [CFG_BITS-1:0] frame_left;
      logic [CFG_BITS-1:0] frame_top;
      logic [CFG_BITS-1:0] frame_width;
      logic [CFG_BITS-1:0] frame_height;
      logic                interlaced;
      logic [KEY_BITS-1:0] transparent_key;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic                  write;
      logic                  frame_end;
      logic [INDEX_BITS-1:0] index;
      logic [RGB_BITS-1:0]   rgb;
      logic [POS_BITS-1:0]   x;
      logic [POS_BITS-1:0]   y;
   } entry_type;

   typedef struct packed {
      logic       found;
      logic [1:0] pass;
   } pass_sel_type;

   function automatic logic [3:0] pass_start(input logic [1:0] p);
      logic [3:0] r;
      case (p)
         2'd0:    r = 4'd0;
         2'd1:    r = 4'd4;
         2'd2:    r = 4'd2;
         default: r = 4'd1;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pass_step(input logic [1:0] p);
      logic [3:0] r;
      case (p)
         2'd0:    r = 4'd8;
         2'd1:    r = 4'd8;
         2'd2:    r = 4'd4;
         default: r = 4'd2;
      endcase
      return r;
   endfunction

   // first later pass whose start row lies inside the frame
   function automatic pass_sel_type next_pass(input logic [1:0] cur,
                                              input logic [CFG_BITS-1:0] height);
      pass_sel_type r;
      r.found = 1'b0;
      r.pass  = 2'd0;
      for (int p = 3; p >= 1; p--) begin
         if (2'(p) > cur && CFG_BITS'(pass_start(2'(p))) < height) begin
            r.found = 1'b1;
            r.pass  = 2'(p);
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/gfpb_front.sv -----
module gfpb_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gfpb_pkg::cfg_type    cfg,
   input  logic                 accept,
   input  gfpb_pkg::op_type     op,
   input  logic [7:0]           color_index,
   input  logic [23:0]          rgb,
   output gfpb_pkg::entry_type  entry
);

   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [1:0]            pass_ff, pass_in;

   logic [gfpb_pkg::POS_BITS-1:0] x, y, col_inc, row_inc, step;
   logic                          row_end, more_rows, frame_end, write;
   gfpb_pkg::pass_sel_type        nxt;

   always_comb begin
      x = {1'b0, cfg.frame_left} + gfpb_pkg::POS_BITS'(column_ff);
      y = {1'b0, cfg.frame_top} + gfpb_pkg::POS_BITS'(row_ff);
      write = (x < {1'b0, cfg.canvas_width}) && (y < {1'b0, cfg.canvas_height})
              && ({1'b0, color_index} != cfg.transparent_key);
      col_inc = gfpb_pkg::POS_BITS'(column_ff) + 1'b1;
      row_end = !(col_inc < {1'b0, cfg.frame_width});
      step = cfg.interlaced ? gfpb_pkg::POS_BITS'(gfpb_pkg::pass_step(pass_ff))
                            : gfpb_pkg::POS_BITS'(1);
      row_inc = gfpb_pkg::POS_BITS'(row_ff) + step;
      more_rows = row_inc < {1'b0, cfg.frame_height};
      nxt = gfpb_pkg::next_pass(pass_ff, cfg.frame_height);
      frame_end = row_end && !more_rows && !(cfg.interlaced && nxt.found);

      column_in = column_ff;
      row_in    = row_ff;
      pass_in   = pass_ff;
      if (accept && op == gfpb_pkg::OP_PIXEL) begin
         if (!row_end) begin
            column_in = col_inc[COORD_BITS-1:0];
         end else begin
            column_in = '0;
            if (more_rows) begin
               row_in = row_inc[COORD_BITS-1:0];
            end else if (cfg.interlaced && nxt.found) begin
               pass_in = nxt.pass;
               row_in  = COORD_BITS'(gfpb_pkg::pass_start(nxt.pass));
            end else begin
               row_in  = '0;
               pass_in = 2'd0;
            end
         end
      end

      entry.op        = op;
      entry.write     = write;
      entry.frame_end = (op == gfpb_pkg::OP_PIXEL) && frame_end;
      entry.index     = color_index;
      entry.rgb       = rgb;
      entry.x         = x;
      entry.y         = y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         pass_ff   <= 2'd0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         pass_ff   <= pass_in;
      end
   end

endmodule

// ----- rtl/gfpb_queue.sv -----
module gfpb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gfpb_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output gfpb_pkg::entry_type  head,
   output logic                 empty
);

   gfpb_pkg::entry_type slot_ff [gfpb_pkg::QUEUE_DEPTH];

   logic [gfpb_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [gfpb_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                           do_push, do_pop;

   always_comb begin
      full    = count_ff == gfpb_pkg::QCNT_BITS'(gfpb_pkg::QUEUE_DEPTH);
      empty   = count_ff == '0;
      do_push = push && !full;
      do_pop  = pop && !empty;
      head    = slot_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/gfpb_back.sv -----
module gfpb_back #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          canvas_width,
   input  gfpb_pkg::entry_type  head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   localparam int PAL_BITS = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [gfpb_pkg::RGB_BITS-1:0] palette [PALETTE_ENTRIES];

   logic                            advance, in_range;
   logic                            s1_valid_ff, s1_valid_in;
   gfpb_pkg::entry_type             s1_ff;
   logic [gfpb_pkg::PROD_BITS-1:0]  prod_ff;
   logic [gfpb_pkg::RGB_BITS-1:0]   colour_ff;
   logic                            in_range_ff;

   logic                            out_valid_ff, out_valid_in;
   logic                            wr_ff, wr_in;
   logic                            end_ff, end_in;
   logic [gfpb_pkg::ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [gfpb_pkg::RGB_BITS-1:0]   rgb_ff, rgb_in;
   logic [gfpb_pkg::PROD_BITS-1:0]  sum;

   always_comb begin
      advance  = !out_valid_ff || rsp_tready;
      pop      = advance && !empty;
      in_range = {1'b0, head.index} < 9'(PALETTE_ENTRIES);
      s1_valid_in = advance ? !empty : s1_valid_ff;

      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
      wr_in  = (s1_ff.op == gfpb_pkg::OP_PIXEL) && s1_ff.write;
      end_in = s1_ff.frame_end;
      sum    = prod_ff + gfpb_pkg::PROD_BITS'(s1_ff.x);
      addr_in = wr_in ? sum[gfpb_pkg::ADDR_BITS-1:0] : '0;
      rgb_in  = (wr_in && in_range_ff) ? colour_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff       <= head;
         prod_ff     <= gfpb_pkg::PROD_BITS'(head.y) * gfpb_pkg::PROD_BITS'(canvas_width);
         in_range_ff <= in_range;
         colour_ff   <= palette[head.index[PAL_BITS-1:0]];
      end
      if (advance) begin
         wr_ff   <= wr_in;
         end_ff  <= end_in;
         addr_ff <= addr_in;
         rgb_ff  <= rgb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.op == gfpb_pkg::OP_LOAD && in_range) begin
         palette[head.index[PAL_BITS-1:0]] <= head.rgb;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rgb_ff[7:0], rgb_ff[15:8], rgb_ff[23:16], addr_ff};
   assign rsp_tuser  = wr_ff;
   assign rsp_tlast  = end_ff;

endmodule

// ----- rtl/gif_frame_pixel_blit_core.sv -----
// An accepted word passes the queue, the s1 stage and the output register before rsp.
// Throughput: one word per clock, palette loads and pixels alike, while rsp does not
// stall; the front counters and the single-port palette each take one word a cycle.
// A four-word queue parts the front from the back; with the two back stages the block
// holds six words while rsp stalls, then req drops until the back pops again.
// Reset (synchronous, active high) sets the registers to their defaults and clears the
// counters and queue; the palette is not cleared.
module gif_frame_pixel_blit_core #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int COORD_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // color_index, load_red, load_green, load_blue
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // write_address, out_red, out_green, out_blue
   output logic        rsp_tuser,   // write_valid
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   gfpb_pkg::cfg_type   cfg_ff, cfg_in;
   gfpb_pkg::entry_type entry, head;
   gfpb_pkg::op_type    op;
   logic                full, empty, pop, accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (gfpb_pkg::reg_index_type'(csr_index))
            gfpb_pkg::REG_CANVAS_WIDTH:  cfg_in.canvas_width    = csr_wdata;
            gfpb_pkg::REG_CANVAS_HEIGHT: cfg_in.canvas_height   = csr_wdata;
            gfpb_pkg::REG_FRAME_LEFT:    cfg_in.frame_left      = csr_wdata;
            gfpb_pkg::REG_FRAME_TOP:     cfg_in.frame_top       = csr_wdata;
            gfpb_pkg::REG_FRAME_WIDTH:   cfg_in.frame_width     = csr_wdata;
            gfpb_pkg::REG_FRAME_HEIGHT:  cfg_in.frame_height    = csr_wdata;
            gfpb_pkg::REG_INTERLACED:    cfg_in.interlaced      = csr_wdata[0];
            gfpb_pkg::REG_TRANSP_KEY:    cfg_in.transparent_key =
                                            csr_wdata[gfpb_pkg::KEY_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width    <= 16'd1;
         cfg_ff.canvas_height   <= 16'd1;
         cfg_ff.frame_left      <= 16'd0;
         cfg_ff.frame_top       <= 16'd0;
         cfg_ff.frame_width     <= 16'd1;
         cfg_ff.frame_height    <= 16'd1;
         cfg_ff.interlaced      <= 1'b0;
         cfg_ff.transparent_key <= gfpb_pkg::KEY_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign op         = gfpb_pkg::op_type'(req_tuser);

   gfpb_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .op          (op),
      .color_index (req_tdata[7:0]),
      .rgb         ({req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]}),
      .entry       (entry)
   );

   gfpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (entry),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   gfpb_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .canvas_width (cfg_ff.canvas_width),
      .head         (head),
      .empty        (empty),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
